/* rtl/bcd_clock_time_setter_macros.svh */
// assertion macros for the rtc time setter
`ifndef BCD_CLOCK_TIME_SETTER_MACROS_SVH
`define BCD_CLOCK_TIME_SETTER_MACROS_SVH

`ifndef SYNTHESIS
// check that cons holds in the same cycle as ante
`define BCDTS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bcd_clock_time_setter: same-cycle check failed");
// check that cons holds in the cycle after ante
`define BCDTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bcd_clock_time_setter: next-cycle check failed");
`else
`define BCDTS_ASSERT_NOW(lbl, ante, cons)
`define BCDTS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* rtl/bcdts_pkg.sv */
`default_nettype none

package bcdts_pkg;

  // command codes
  typedef enum logic [2:0] {
    OP_HALT  = 3'd0,
    OP_MODE  = 3'd1,
    OP_SEC   = 3'd2,
    OP_MIN   = 3'd3,
    OP_HOUR  = 3'd4,
    OP_DATE  = 3'd5,
    OP_MONTH = 3'd6,
    OP_YEAR  = 3'd7
  } op_t;

  typedef struct packed {
    logic [4:0] tens;
    logic [3:0] units;
  } digits_t;

  localparam logic [6:0] SEC_RST   = 7'h00;
  localparam logic [6:0] MIN_RST   = 7'h00;
  localparam logic [6:0] HOUR_RST  = 7'h00;
  localparam logic [5:0] DATE_RST  = 6'h01;
  localparam logic [4:0] MONTH_RST = 5'h01;
  localparam logic [7:0] YEAR_RST  = 8'h14;

  localparam logic [7:0] MINSEC_TOP = 8'd59;
  localparam logic [7:0] H12_TOP    = 8'd12;
  localparam logic [7:0] H24_TOP    = 8'd23;
  localparam logic [7:0] YEAR_TOP   = 8'd99;

  // tens * 10 + units, nibbles taken as they are
  function automatic logic [7:0] bcd2bin(input logic [7:0] b);
    logic [7:0] t;
    t = {4'b0, b[7:4]};
    return (t << 3) + (t << 1) + {4'b0, b[3:0]};
  endfunction

  // split into decimal digits, reciprocal multiply exact below 1029
  function automatic digits_t div10(input logic [7:0] v);
    logic [15:0] prod;
    logic [7:0]  t;
    logic [7:0]  rem;
    digits_t     d;
    prod    = {8'b0, v} * 16'd205;
    d.tens  = prod[15:11];
    t       = {3'b0, d.tens};
    rem     = v - (t << 3) - (t << 1);
    d.units = rem[3:0];
    return d;
  endfunction

  function automatic logic [7:0] month_days(input logic [7:0] m, input logic leap);
    logic [7:0] lim;
    case (m)
      8'd2:                      lim = leap ? 8'd29 : 8'd28;
      8'd4, 8'd6, 8'd9, 8'd11:   lim = 8'd30;
      default:                   lim = 8'd31;
    endcase
    return lim;
  endfunction

  // binary day, month and two-digit year
  function automatic logic date_ok(input logic [7:0] d, input logic [7:0] m,
                                   input logic [7:0] y);
    logic leap;
    leap = (y[1:0] == 2'b00);
    return (y <= YEAR_TOP) && (m >= 8'd1) && (m <= 8'd12) && (d >= 8'd1) &&
           (d <= month_days(m, leap));
  endfunction

endpackage

`default_nettype wire

/* rtl/bcd_clock_time_setter.sv */
// bcd real-time clock time setter
//
// input channel: in_valid / in_stall carry one command word (in_op,
// in_direction, in_flag). a word is taken at a rising edge with in_valid
// high and in_stall low.
// output channel: out_valid / out_stall carry one result word per command,
// holding the full register image (seconds with halt bit, minutes, hours
// with mode and pm bits, date, month, year) as it stands after the command.
// the command register feeds a single pass of bcd step, mode conversion
// and calendar check into the time registers, which double as the output
// register; a command moves on once the result slot is free. throughput:
// one command per cycle while out_stall is low.
// stall: while out_stall holds a pending result, the command register
// still takes one word; in_stall rises only when both stages are full.
// reset (rst_n low, synchronous): both channels empty, time 00:00:00 in
// 24-hour mode, halt clear, date 01/01, year 14.
`default_nettype none

`include "bcd_clock_time_setter_macros.svh"

module bcd_clock_time_setter (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [2:0] in_op,
  input  wire logic       in_direction,
  input  wire logic       in_flag,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_seconds_reg,
  output logic [6:0]      out_minutes_reg,
  output logic [6:0]      out_hours_reg,
  output logic [5:0]      out_date_reg,
  output logic [4:0]      out_month_reg,
  output logic [7:0]      out_year_reg
);

  // command stage
  logic             cmd_valid_r, cmd_valid_nxt;
  bcdts_pkg::op_t   op_r;
  logic             dir_r;
  logic             flag_r;

  // time registers, also the result word
  logic             res_valid_r, res_valid_nxt;
  logic             halt_r, halt_nxt;
  logic [6:0]       sec_r, sec_nxt;
  logic [6:0]       min_r, min_nxt;
  logic [6:0]       hour_r, hour_nxt;
  logic [5:0]       date_r, date_nxt;
  logic [4:0]       month_r, month_nxt;
  logic [7:0]       year_r, year_nxt;

  logic             res_free;
  logic             advance;
  logic             take_in;

  // binary views of the stored fields
  logic [7:0]       sec_v, min_v, h12_v, h24_v, day_v, mon_v, yr_v;

  // stepped value in binary, pm bit and calendar check
  logic [7:0]       bin_v;
  logic             pm_v;
  logic             cal_ok;
  bcdts_pkg::digits_t dig;

  // handshake: result slot frees when empty or being taken
  assign res_free = !res_valid_r || !out_stall;
  assign advance  = cmd_valid_r && res_free;
  assign in_stall = cmd_valid_r && !res_free;
  assign take_in  = in_valid && !in_stall;

  assign cmd_valid_nxt = take_in || (cmd_valid_r && !advance);
  assign res_valid_nxt = advance || (res_valid_r && out_stall);

  assign sec_v = bcdts_pkg::bcd2bin({1'b0, sec_r});
  assign min_v = bcdts_pkg::bcd2bin({1'b0, min_r});
  assign h12_v = bcdts_pkg::bcd2bin({3'b0, hour_r[4:0]});
  assign h24_v = bcdts_pkg::bcd2bin({2'b0, hour_r[5:0]});
  assign day_v = bcdts_pkg::bcd2bin({2'b0, date_r});
  assign mon_v = bcdts_pkg::bcd2bin({3'b0, month_r});
  assign yr_v  = bcdts_pkg::bcd2bin(year_r);

  // one step per command, all commands share the digit split below
  always_comb begin
    bin_v  = '0;
    pm_v   = 1'b0;
    cal_ok = 1'b0;
    case (op_r)
      bcdts_pkg::OP_HALT: begin
        bin_v = '0;
      end
      bcdts_pkg::OP_MODE: begin
        if (flag_r) begin
          // 24-hour to 12-hour
          if (h24_v >= bcdts_pkg::H12_TOP) begin
            pm_v  = 1'b1;
            bin_v = (h24_v > bcdts_pkg::H12_TOP) ? h24_v - bcdts_pkg::H12_TOP : h24_v;
          end else begin
            pm_v  = 1'b0;
            bin_v = (h24_v == 8'd0) ? bcdts_pkg::H12_TOP : h24_v;
          end
        end else begin
          // 12-hour to 24-hour
          pm_v = hour_r[5];
          if (pm_v && h12_v != bcdts_pkg::H12_TOP) begin
            bin_v = h12_v + bcdts_pkg::H12_TOP;
          end else if (!pm_v && h12_v == bcdts_pkg::H12_TOP) begin
            bin_v = 8'd0;
          end else begin
            bin_v = h12_v;
          end
        end
      end
      bcdts_pkg::OP_SEC: begin
        if (dir_r) begin
          bin_v = (sec_v < bcdts_pkg::MINSEC_TOP) ? sec_v + 8'd1 : 8'd0;
        end else begin
          bin_v = (sec_v != 8'd0) ? sec_v - 8'd1 : bcdts_pkg::MINSEC_TOP;
        end
      end
      bcdts_pkg::OP_MIN: begin
        if (dir_r) begin
          bin_v = (min_v < bcdts_pkg::MINSEC_TOP) ? min_v + 8'd1 : 8'd0;
        end else begin
          bin_v = (min_v != 8'd0) ? min_v - 8'd1 : bcdts_pkg::MINSEC_TOP;
        end
      end
      bcdts_pkg::OP_HOUR: begin
        if (hour_r[6]) begin
          // 1..12, pm flips on either wrap
          pm_v = hour_r[5];
          if (dir_r) begin
            if (h12_v < bcdts_pkg::H12_TOP) begin
              bin_v = h12_v + 8'd1;
            end else begin
              bin_v = 8'd1;
              pm_v  = !hour_r[5];
            end
          end else begin
            if (h12_v > 8'd1) begin
              bin_v = h12_v - 8'd1;
            end else begin
              bin_v = bcdts_pkg::H12_TOP;
              pm_v  = !hour_r[5];
            end
          end
        end else begin
          if (dir_r) begin
            bin_v = (h24_v < bcdts_pkg::H24_TOP) ? h24_v + 8'd1 : 8'd0;
          end else begin
            bin_v = (h24_v != 8'd0) ? h24_v - 8'd1 : bcdts_pkg::H24_TOP;
          end
        end
      end
      // a step out of range (day or month 0, year below zero wrapping to 255) fails the calendar check
      bcdts_pkg::OP_DATE: begin
        bin_v  = dir_r ? day_v + 8'd1 : day_v - 8'd1;
        cal_ok = bcdts_pkg::date_ok(bin_v, mon_v, yr_v);
      end
      bcdts_pkg::OP_MONTH: begin
        bin_v  = dir_r ? mon_v + 8'd1 : mon_v - 8'd1;
        cal_ok = bcdts_pkg::date_ok(day_v, bin_v, yr_v);
      end
      bcdts_pkg::OP_YEAR: begin
        bin_v  = dir_r ? yr_v + 8'd1 : yr_v - 8'd1;
        cal_ok = bcdts_pkg::date_ok(day_v, mon_v, bin_v);
      end
      default: begin
        bin_v = '0;
      end
    endcase
  end

  assign dig = bcdts_pkg::div10(bin_v);

  // write back, tens digit truncated to the width of its field
  always_comb begin
    halt_nxt  = halt_r;
    sec_nxt   = sec_r;
    min_nxt   = min_r;
    hour_nxt  = hour_r;
    date_nxt  = date_r;
    month_nxt = month_r;
    year_nxt  = year_r;
    if (advance) begin
      halt_nxt = (op_r == bcdts_pkg::OP_HALT) ? flag_r : 1'b0;
      case (op_r)
        bcdts_pkg::OP_HALT: begin
          sec_nxt = sec_r;
        end
        bcdts_pkg::OP_MODE: begin
          // same mode leaves the hour alone
          if (hour_r[6] != flag_r) begin
            if (flag_r) begin
              hour_nxt = {1'b1, pm_v, dig.tens[0], dig.units};
            end else begin
              hour_nxt = {1'b0, dig.tens[1:0], dig.units};
            end
          end
        end
        bcdts_pkg::OP_SEC: begin
          sec_nxt = {dig.tens[2:0], dig.units};
        end
        bcdts_pkg::OP_MIN: begin
          min_nxt = {dig.tens[2:0], dig.units};
        end
        bcdts_pkg::OP_HOUR: begin
          if (hour_r[6]) begin
            hour_nxt = {1'b1, pm_v, dig.tens[0], dig.units};
          end else begin
            hour_nxt = {1'b0, dig.tens[1:0], dig.units};
          end
        end
        bcdts_pkg::OP_DATE: begin
          if (cal_ok) begin
            date_nxt = {dig.tens[1:0], dig.units};
          end
        end
        bcdts_pkg::OP_MONTH: begin
          if (cal_ok) begin
            month_nxt = {dig.tens[0], dig.units};
          end
        end
        bcdts_pkg::OP_YEAR: begin
          if (cal_ok) begin
            year_nxt = {dig.tens[3:0], dig.units};
          end
        end
        default: begin
          sec_nxt = sec_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid_r <= 1'b0;
      res_valid_r <= 1'b0;
      halt_r      <= 1'b0;
      sec_r       <= bcdts_pkg::SEC_RST;
      min_r       <= bcdts_pkg::MIN_RST;
      hour_r      <= bcdts_pkg::HOUR_RST;
      date_r      <= bcdts_pkg::DATE_RST;
      month_r     <= bcdts_pkg::MONTH_RST;
      year_r      <= bcdts_pkg::YEAR_RST;
    end else begin
      cmd_valid_r <= cmd_valid_nxt;
      res_valid_r <= res_valid_nxt;
      halt_r      <= halt_nxt;
      sec_r       <= sec_nxt;
      min_r       <= min_nxt;
      hour_r      <= hour_nxt;
      date_r      <= date_nxt;
      month_r     <= month_nxt;
      year_r      <= year_nxt;
    end
  end

  // command word, no reset needed
  always_ff @(posedge clk) begin
    if (take_in) begin
      op_r   <= bcdts_pkg::op_t'(in_op);
      dir_r  <= in_direction;
      flag_r <= in_flag;
    end
  end

  assign out_valid       = res_valid_r;
  assign out_seconds_reg = {halt_r, sec_r};
  assign out_minutes_reg = min_r;
  assign out_hours_reg   = hour_r;
  assign out_date_reg    = date_r;
  assign out_month_reg   = month_r;
  assign out_year_reg    = year_r;

  // calendar fields always form a valid date
  `BCDTS_ASSERT_NOW(a_cal_valid, 1'b1, bcdts_pkg::date_ok(day_v, mon_v, yr_v))
  // seconds and minutes stay proper bcd below 60
  `BCDTS_ASSERT_NOW(a_sec_bcd, 1'b1, sec_r[6:4] <= 3'd5 && sec_r[3:0] <= 4'd9)
  `BCDTS_ASSERT_NOW(a_min_bcd, 1'b1, min_r[6:4] <= 3'd5 && min_r[3:0] <= 4'd9)
  // any command but set-halt clears halt
  `BCDTS_ASSERT_NEXT(a_halt_clear, advance && op_r != bcdts_pkg::OP_HALT, !halt_r && out_valid)
  // back-pressure only with a command waiting
  `BCDTS_ASSERT_NOW(a_stall_full, in_stall, cmd_valid_r && res_valid_r)

endmodule

`default_nettype wire
